>>> rtl/scl_pkg.sv
// Package for the source character lexer: codes, token record and helpers.
package scl_pkg;

  localparam int unsigned OffsetBitsDefault = 24;
  localparam int unsigned FieldBits = 24;
  localparam int unsigned FifoDepth = 4;

  localparam logic [FieldBits-1:0] FieldMax = {FieldBits{1'b1}};

  // Scanner modes.
  typedef enum logic [3:0] {
    MODE_IDLE    = 4'd0,
    MODE_INT     = 4'd1,
    MODE_IDENT   = 4'd2,
    MODE_SLASH   = 4'd3,
    MODE_COMMENT = 4'd4,
    MODE_BANG    = 4'd5,
    MODE_EQ      = 4'd6,
    MODE_GT      = 4'd7,
    MODE_LT      = 4'd8
  } mode_e;

  // Token kinds.
  typedef enum logic [4:0] {
    KIND_EOF    = 5'd0,
    KIND_ERROR  = 5'd1,
    KIND_INT    = 5'd2,
    KIND_IDENT  = 5'd3,
    KIND_KW_IF  = 5'd4,
    KIND_KW_INT = 5'd5,
    KIND_KW_ELS = 5'd6,
    KIND_KW_PRT = 5'd7,
    KIND_KW_WHL = 5'd8,
    KIND_PLUS   = 5'd9,
    KIND_MINUS  = 5'd10,
    KIND_STAR   = 5'd11,
    KIND_SLASH  = 5'd12,
    KIND_LPAREN = 5'd13,
    KIND_RPAREN = 5'd14,
    KIND_LBRACE = 5'd15,
    KIND_RBRACE = 5'd16,
    KIND_SEMI   = 5'd17,
    KIND_BANG   = 5'd18,
    KIND_NE     = 5'd19,
    KIND_ASSIGN = 5'd20,
    KIND_EQEQ   = 5'd21,
    KIND_GT     = 5'd22,
    KIND_GE     = 5'd23,
    KIND_LT     = 5'd24,
    KIND_LE     = 5'd25
  } kind_e;

  // Character codes.
  localparam logic [7:0] CH_NUL    = 8'h00;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_LF     = 8'h0A;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_BANG   = 8'h21;
  localparam logic [7:0] CH_LPAREN = 8'h28;
  localparam logic [7:0] CH_RPAREN = 8'h29;
  localparam logic [7:0] CH_STAR   = 8'h2A;
  localparam logic [7:0] CH_PLUS   = 8'h2B;
  localparam logic [7:0] CH_MINUS  = 8'h2D;
  localparam logic [7:0] CH_SLASH  = 8'h2F;
  localparam logic [7:0] CH_SEMI   = 8'h3B;
  localparam logic [7:0] CH_LT     = 8'h3C;
  localparam logic [7:0] CH_EQ     = 8'h3D;
  localparam logic [7:0] CH_GT     = 8'h3E;
  localparam logic [7:0] CH_USCORE = 8'h5F;
  localparam logic [7:0] CH_LBRACE = 8'h7B;
  localparam logic [7:0] CH_RBRACE = 8'h7D;

  // Keywords, packed first character highest.
  localparam logic [39:0] KW_IF    = 40'h00_0000_6966;
  localparam logic [39:0] KW_INT   = 40'h00_0069_6E74;
  localparam logic [39:0] KW_ELSE  = 40'h00_656C_7365;
  localparam logic [39:0] KW_PRINT = 40'h70_7269_6E74;
  localparam logic [39:0] KW_WHILE = 40'h77_6869_6C65;

  typedef struct packed {
    logic                 last;
    logic [FieldBits-1:0] line;
    logic [FieldBits-1:0] length;
    logic [FieldBits-1:0] start;
    kind_e                kind;
  } token_t;

  function automatic logic is_decimal(input logic [7:0] c);
    return (c >= 8'h30) && (c <= 8'h39);
  endfunction

  function automatic logic is_alpha(input logic [7:0] c);
    return ((c >= 8'h61) && (c <= 8'h7A)) || ((c >= 8'h41) && (c <= 8'h5A))
        || (c == CH_USCORE);
  endfunction

  function automatic kind_e ident_kind(input logic [39:0] prefix, input logic too_long);
    kind_e k;
    k = KIND_IDENT;
    if (!too_long) begin
      unique case (prefix)
        KW_IF:    k = KIND_KW_IF;
        KW_INT:   k = KIND_KW_INT;
        KW_ELSE:  k = KIND_KW_ELS;
        KW_PRINT: k = KIND_KW_PRT;
        KW_WHILE: k = KIND_KW_WHL;
        default:  k = KIND_IDENT;
      endcase
    end
    return k;
  endfunction

endpackage

>>> rtl/source_char_lexer_core.sv
// Source character lexer: scanner state, token formation and token queue.
// Queueing: a token is registered into the token queue when the request that completes
//   it is accepted (two tokens from one character are queued and leave in order).
// Throughput: one character per cycle; input stalls only while the 4-entry
//   token queue holds more than two tokens.
// Reset: rst_ni is asynchronous, active low; it empties the queue and sets
//   mode idle, offset 0, line 1. A NUL character restarts the scanner likewise.
module source_char_lexer_core #(
  parameter int unsigned OFFSET_BITS = scl_pkg::OffsetBitsDefault
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // slave side: [7:0] ch
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [7:0]  s_axis_tdata_i,
  // master side: [4:0] token_kind, [28:5] token_start, [52:29] token_length,
  //   [76:53] token_line, [79:77] zero
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [79:0] m_axis_tdata_o,
  output logic        m_axis_tlast_o
);
  import scl_pkg::*;

  localparam int unsigned LenBits   = (OFFSET_BITS > FieldBits) ? OFFSET_BITS : FieldBits;
  localparam int unsigned PtrBits   = $clog2(FifoDepth);
  localparam int unsigned CntBits   = $clog2(FifoDepth + 1);
  localparam logic [OFFSET_BITS-1:0] PosMax = {OFFSET_BITS{1'b1}};

  // Scanner state
  mode_e                  mode_q, mode_d;
  logic [OFFSET_BITS-1:0] pos_q, pos_d;
  logic [OFFSET_BITS-1:0] begin_q, begin_d;
  logic [FieldBits-1:0]   line_q, line_d;
  logic [39:0]            prefix_q, prefix_d;
  logic                   too_long_q, too_long_d;

  // Token queue
  token_t               fifo_q [FifoDepth];
  logic [PtrBits-1:0]   wr_ptr_q, rd_ptr_q;
  logic [CntBits-1:0]   cnt_q, cnt_d;

  logic [7:0]             ch;
  logic                   accept, pop;
  logic [OFFSET_BITS-1:0] diff;
  logic [LenBits-1:0]     diff_ext, begin_ext, pos_ext;
  logic [FieldBits-1:0]   run_len, begin_lo, pos_lo;

  // Closing token (from the pending mode) and fresh token (from this character)
  logic   close_v, fresh_v, fresh;
  kind_e  close_kind, fresh_kind, op_kind, op_eq_kind;
  logic   op_pending;
  logic [FieldBits-1:0] close_len;
  token_t tok_first, tok_second;
  logic [1:0] push_n;

  assign ch     = s_axis_tdata_i;
  assign accept = s_axis_tvalid_i && s_axis_tready_o;
  assign pop    = m_axis_tvalid_o && m_axis_tready_i;

  assign diff      = pos_q - begin_q;
  assign diff_ext  = LenBits'(diff);
  assign begin_ext = LenBits'(begin_q);
  assign pos_ext   = LenBits'(pos_q);
  assign run_len   = (diff_ext > LenBits'(FieldMax)) ? FieldMax : diff_ext[FieldBits-1:0];
  assign begin_lo  = begin_ext[FieldBits-1:0];
  assign pos_lo    = pos_ext[FieldBits-1:0];

  // Per-character scan, one pass per request
  always_comb begin
    mode_d     = mode_q;
    begin_d    = begin_q;
    line_d     = line_q;
    prefix_d   = prefix_q;
    too_long_d = too_long_q;
    close_v    = 1'b0;
    close_kind = KIND_ERROR;
    close_len  = FieldBits'(1);
    fresh      = 1'b1;
    fresh_v    = 1'b0;
    fresh_kind = KIND_ERROR;
    op_pending = 1'b0;
    op_kind    = KIND_BANG;
    op_eq_kind = KIND_NE;

    // close or extend whatever is pending
    unique case (mode_q)
      MODE_INT: begin
        if (is_decimal(ch)) begin
          fresh = 1'b0;
        end else begin
          close_v    = 1'b1;
          close_kind = KIND_INT;
          close_len  = run_len;
        end
      end
      MODE_IDENT: begin
        if (is_decimal(ch) || is_alpha(ch)) begin
          fresh = 1'b0;
          if (!too_long_q) begin
            if (diff < OFFSET_BITS'(5)) begin
              prefix_d = {prefix_q[31:0], ch};
            end else begin
              too_long_d = 1'b1;
            end
          end
        end else begin
          close_v    = 1'b1;
          close_kind = ident_kind(prefix_q, too_long_q);
          close_len  = run_len;
        end
      end
      MODE_SLASH: begin
        if (ch == CH_SLASH) begin
          mode_d = MODE_COMMENT;
          fresh  = 1'b0;
        end else begin
          close_v    = 1'b1;
          close_kind = KIND_SLASH;
        end
      end
      MODE_COMMENT: begin
        if (ch == CH_LF) begin
          if (line_q != FieldMax) line_d = line_q + FieldBits'(1);
          mode_d = MODE_IDLE;
          fresh  = 1'b0;
        end else if (ch != CH_NUL) begin
          fresh = 1'b0;
        end
      end
      MODE_BANG: begin op_pending = 1'b1; op_kind = KIND_BANG;   op_eq_kind = KIND_NE;   end
      MODE_EQ:   begin op_pending = 1'b1; op_kind = KIND_ASSIGN; op_eq_kind = KIND_EQEQ; end
      MODE_GT:   begin op_pending = 1'b1; op_kind = KIND_GT;     op_eq_kind = KIND_GE;   end
      MODE_LT:   begin op_pending = 1'b1; op_kind = KIND_LT;     op_eq_kind = KIND_LE;   end
      default: ;
    endcase

    // one of ! = > < waiting for an optional '='
    if (op_pending) begin
      close_v = 1'b1;
      if (ch == CH_EQ) begin
        close_kind = op_eq_kind;
        close_len  = FieldBits'(2);
        mode_d     = MODE_IDLE;
        fresh      = 1'b0;
      end else begin
        close_kind = op_kind;
      end
    end

    // start of something new
    if (fresh) begin
      mode_d = MODE_IDLE;
      unique case (ch)
        CH_SPACE, CH_TAB: ;
        CH_LF:     if (line_q != FieldMax) line_d = line_q + FieldBits'(1);
        CH_NUL:    begin fresh_v = 1'b1; fresh_kind = KIND_EOF; end
        CH_SLASH:  begin mode_d = MODE_SLASH; begin_d = pos_q; end
        CH_BANG:   begin mode_d = MODE_BANG;  begin_d = pos_q; end
        CH_EQ:     begin mode_d = MODE_EQ;    begin_d = pos_q; end
        CH_GT:     begin mode_d = MODE_GT;    begin_d = pos_q; end
        CH_LT:     begin mode_d = MODE_LT;    begin_d = pos_q; end
        CH_PLUS:   begin fresh_v = 1'b1; fresh_kind = KIND_PLUS;   end
        CH_MINUS:  begin fresh_v = 1'b1; fresh_kind = KIND_MINUS;  end
        CH_STAR:   begin fresh_v = 1'b1; fresh_kind = KIND_STAR;   end
        CH_LPAREN: begin fresh_v = 1'b1; fresh_kind = KIND_LPAREN; end
        CH_RPAREN: begin fresh_v = 1'b1; fresh_kind = KIND_RPAREN; end
        CH_LBRACE: begin fresh_v = 1'b1; fresh_kind = KIND_LBRACE; end
        CH_RBRACE: begin fresh_v = 1'b1; fresh_kind = KIND_RBRACE; end
        CH_SEMI:   begin fresh_v = 1'b1; fresh_kind = KIND_SEMI;   end
        default: begin
          if (is_decimal(ch)) begin
            mode_d  = MODE_INT;
            begin_d = pos_q;
          end else if (is_alpha(ch)) begin
            mode_d     = MODE_IDENT;
            begin_d    = pos_q;
            prefix_d   = {32'd0, ch};
            too_long_d = 1'b0;
          end else begin
            fresh_v = 1'b1;  // stray character
          end
        end
      endcase
    end

    // offset update, or full restart on NUL
    pos_d = (pos_q != PosMax) ? pos_q + OFFSET_BITS'(1) : pos_q;
    if (ch == CH_NUL) begin
      mode_d     = MODE_IDLE;
      pos_d      = '0;
      begin_d    = '0;
      line_d     = FieldBits'(1);
      prefix_d   = '0;
      too_long_d = 1'b0;
    end
  end

  // Order the tokens of this character, last flag on the final one
  always_comb begin
    tok_second.kind   = fresh_kind;
    tok_second.start  = pos_lo;
    tok_second.length = (fresh_kind == KIND_EOF) ? '0 : FieldBits'(1);
    tok_second.line   = line_q;
    tok_second.last   = 1'b1;
    tok_first.kind    = close_kind;
    tok_first.start   = begin_lo;
    tok_first.length  = close_len;
    tok_first.line    = line_q;
    tok_first.last    = !fresh_v;
    if (!close_v) tok_first = tok_second;
    push_n = accept ? ({1'b0, close_v} + {1'b0, fresh_v}) : 2'd0;
  end

  assign cnt_d = cnt_q + CntBits'(push_n) - CntBits'(pop);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q     <= MODE_IDLE;
      pos_q      <= '0;
      begin_q    <= '0;
      line_q     <= FieldBits'(1);
      prefix_q   <= '0;
      too_long_q <= 1'b0;
      wr_ptr_q   <= '0;
      rd_ptr_q   <= '0;
      cnt_q      <= '0;
    end else begin
      if (accept) begin
        mode_q     <= mode_d;
        pos_q      <= pos_d;
        begin_q    <= begin_d;
        line_q     <= line_d;
        prefix_q   <= prefix_d;
        too_long_q <= too_long_d;
      end
      wr_ptr_q <= wr_ptr_q + PtrBits'(push_n);
      if (pop) rd_ptr_q <= rd_ptr_q + PtrBits'(1);
      cnt_q <= cnt_d;
    end
  end

  // queue payload, no reset
  always_ff @(posedge clk_i) begin
    if (push_n != 2'd0) fifo_q[wr_ptr_q] <= tok_first;
    if (push_n == 2'd2) fifo_q[wr_ptr_q + PtrBits'(1)] <= tok_second;
  end

  // room for the worst case of two tokens per character
  assign s_axis_tready_o = (cnt_q <= CntBits'(FifoDepth - 2));
  assign m_axis_tvalid_o = (cnt_q != '0);
  assign m_axis_tdata_o  = {3'd0, fifo_q[rd_ptr_q].line, fifo_q[rd_ptr_q].length,
                            fifo_q[rd_ptr_q].start, fifo_q[rd_ptr_q].kind};
  assign m_axis_tlast_o  = fifo_q[rd_ptr_q].last;

  // Checks
  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CntBits'(FifoDepth))
    else $error("token queue overfilled");

  a_nul_restart: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && ch == CH_NUL) |=> (pos_q == '0 && mode_q == MODE_IDLE
                                  && line_q == FieldBits'(1)))
    else $error("NUL did not restart the scanner");

  a_nul_eof: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && ch == CH_NUL) |=> (cnt_q != '0))
    else $error("NUL produced no EOF token");

  a_line_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    line_q != '0)
    else $error("line count reached zero");

  a_pos_monotonic: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && ch != CH_NUL) |=> (pos_q >= $past(pos_q)))
    else $error("offset went backwards");

endmodule
